FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define TMV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmv assertion failed");

`define TMV_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define TMV_ASSERT(lbl, prop)
`define TMV_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

FILE: rtl/tmv_pkg.sv
// ----------------------------------------------------------------------------
// tmv_pkg
// shared types, sizes and character codes of the tag markup validator
// ----------------------------------------------------------------------------
package tmv_pkg;

    localparam int MaxDepth   = 32;
    localparam int MaxNameLen = 9;

    localparam int CountW     = $clog2(MaxDepth + 1);
    localparam int NameCountW = $clog2(MaxNameLen + 1);
    localparam int NameIdxW   = (MaxNameLen > 1) ? $clog2(MaxNameLen) : 1;
    localparam int CdataLen   = 7;
    localparam int MatchW     = 3;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_Z      = 8'h5A;

    typedef enum logic [2:0] {
        MODE_CONTENT,
        MODE_LT,
        MODE_OPEN_NAME,
        MODE_CLOSE_NAME,
        MODE_CDATA_OPEN,
        MODE_CDATA_BODY
    } mode_t;

    typedef logic [MaxNameLen-1:0][4:0] letters_t;

    typedef struct packed {
        letters_t              letters;
        logic [NameCountW-1:0] len;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic              fail;
        logic              root_closed;
    } parser_stat_t;

    // "[CDATA[" opener, one character per position
    function automatic logic [7:0] cdata_char(input logic [MatchW-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_LBRACK;
            3'd1:    c = CH_C;
            3'd2:    c = CH_D;
            3'd3:    c = CH_A;
            3'd4:    c = CH_T;
            3'd5:    c = CH_A;
            3'd6:    c = CH_LBRACK;
            default: c = CH_LBRACK;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/tmv_stack_cell.sv
// ----------------------------------------------------------------------------
// tmv_stack_cell
// one entry of the tag stack; shifts down on push and up on pop
// ----------------------------------------------------------------------------
module tmv_stack_cell (
    input  logic                  clk,
    input  tmv_pkg::stack_ctrl_t  ctrl,
    input  tmv_pkg::entry_t       up_entry,
    input  tmv_pkg::entry_t       down_entry,
    output tmv_pkg::entry_t       entry
);

    tmv_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_reg <= up_entry;
        end
        else if (ctrl.pop)
        begin
            entry_reg <= down_entry;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/tmv_parser.sv
// ----------------------------------------------------------------------------
// tmv_parser
// per-word parse state machine; drives the stack cells and forms the verdict
// ----------------------------------------------------------------------------
module tmv_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             ch,
    input  logic                   last,
    input  tmv_pkg::entry_t        top_entry,
    output tmv_pkg::entry_t        new_entry,
    output tmv_pkg::stack_ctrl_t   ctrl,
    output tmv_pkg::parser_stat_t  stat,
    output logic                   verdict
);

    tmv_pkg::mode_t                       mode_reg, mode_next;
    logic                                 fail_reg, fail_next;
    logic                                 root_reg, root_next;
    tmv_pkg::letters_t                    letters_reg, letters_next;
    logic [tmv_pkg::NameCountW-1:0]       ncount_reg, ncount_next;
    logic [tmv_pkg::MatchW-1:0]           match_reg, match_next;
    logic [tmv_pkg::CountW-1:0]           count_reg, count_next;

    logic       is_upper;
    logic [7:0] diff;
    logic [4:0] letter;

    assign is_upper = (ch >= tmv_pkg::CH_A) && (ch <= tmv_pkg::CH_Z);
    assign diff     = ch - tmv_pkg::CH_A;
    assign letter   = diff[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= tmv_pkg::MODE_CONTENT;
            fail_reg    <= 1'b0;
            root_reg    <= 1'b0;
            letters_reg <= '0;
            ncount_reg  <= '0;
            match_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            fail_reg    <= fail_next;
            root_reg    <= root_next;
            letters_reg <= letters_next;
            ncount_reg  <= ncount_next;
            match_reg   <= match_next;
            count_reg   <= count_next;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        fail_next    = fail_reg;
        root_next    = root_reg;
        letters_next = letters_reg;
        ncount_next  = ncount_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        ctrl         = '0;

        if (accept && !fail_reg)
        begin
            case (mode_reg)
                tmv_pkg::MODE_CONTENT:
                begin
                    if (ch == tmv_pkg::CH_LT)
                    begin
                        if (root_reg)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = tmv_pkg::MODE_LT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        fail_next = 1'b1;
                    end
                end
                tmv_pkg::MODE_LT:
                begin
                    letters_next = '0;
                    ncount_next  = '0;
                    match_next   = '0;
                    if (ch == tmv_pkg::CH_SLASH)
                    begin
                        mode_next = tmv_pkg::MODE_CLOSE_NAME;
                    end
                    else if (ch == tmv_pkg::CH_BANG)
                    begin
                        if (count_reg == '0)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = tmv_pkg::MODE_CDATA_OPEN;
                        end
                    end
                    else
                    begin
                        mode_next = tmv_pkg::MODE_OPEN_NAME;
                        if (!is_upper)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            letters_next[0] = letter;
                            ncount_next     = tmv_pkg::NameCountW'(1);
                        end
                    end
                end
                tmv_pkg::MODE_OPEN_NAME:
                begin
                    if (ch == tmv_pkg::CH_GT)
                    begin
                        if (ncount_reg == '0 ||
                            count_reg >= tmv_pkg::CountW'(tmv_pkg::MaxDepth))
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.push  = 1'b1;
                            count_next = count_reg + 1'b1;
                            mode_next  = tmv_pkg::MODE_CONTENT;
                        end
                    end
                    else if (!is_upper ||
                             ncount_reg >= tmv_pkg::NameCountW'(tmv_pkg::MaxNameLen))
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        letters_next[ncount_reg[tmv_pkg::NameIdxW-1:0]] = letter;
                        ncount_next = ncount_reg + 1'b1;
                    end
                end
                tmv_pkg::MODE_CLOSE_NAME:
                begin
                    if (count_reg == '0)
                    begin
                        fail_next = 1'b1;
                    end
                    else if (ch == tmv_pkg::CH_GT)
                    begin
                        if (ncount_reg != top_entry.len)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.pop   = 1'b1;
                            count_next = count_reg - 1'b1;
                            if (count_reg == tmv_pkg::CountW'(1))
                            begin
                                root_next = 1'b1;
                            end
                            mode_next = tmv_pkg::MODE_CONTENT;
                        end
                    end
                    else if (!is_upper || ncount_reg >= top_entry.len)
                    begin
                        fail_next = 1'b1;
                    end
                    else if (top_entry.letters[ncount_reg[tmv_pkg::NameIdxW-1:0]] != letter)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        ncount_next = ncount_reg + 1'b1;
                    end
                end
                tmv_pkg::MODE_CDATA_OPEN:
                begin
                    if (match_reg >= tmv_pkg::MatchW'(tmv_pkg::CdataLen) ||
                        ch != tmv_pkg::cdata_char(match_reg))
                    begin
                        fail_next = 1'b1;
                    end
                    else if (match_reg == tmv_pkg::MatchW'(tmv_pkg::CdataLen - 1))
                    begin
                        match_next = '0;
                        mode_next  = tmv_pkg::MODE_CDATA_BODY;
                    end
                    else
                    begin
                        match_next = match_reg + 1'b1;
                    end
                end
                tmv_pkg::MODE_CDATA_BODY:
                begin
                    if (ch == tmv_pkg::CH_RBRACK)
                    begin
                        if (match_reg < tmv_pkg::MatchW'(2))
                        begin
                            match_next = match_reg + 1'b1;
                        end
                    end
                    else if (ch == tmv_pkg::CH_GT && match_reg == tmv_pkg::MatchW'(2))
                    begin
                        match_next = '0;
                        mode_next  = tmv_pkg::MODE_CONTENT;
                    end
                    else
                    begin
                        match_next = '0;
                    end
                end
                default:
                begin
                    fail_next = 1'b1;
                end
            endcase
        end

        verdict = !fail_next && (mode_next == tmv_pkg::MODE_CONTENT) &&
                  (count_next == '0) && root_next;

        // end of text: start over
        if (accept && last)
        begin
            mode_next    = tmv_pkg::MODE_CONTENT;
            fail_next    = 1'b0;
            root_next    = 1'b0;
            letters_next = '0;
            ncount_next  = '0;
            match_next   = '0;
            count_next   = '0;
        end
    end

    assign new_entry.letters = letters_reg;
    assign new_entry.len     = ncount_reg;

    assign stat.count       = count_reg;
    assign stat.fail        = fail_reg;
    assign stat.root_closed = root_reg;

endmodule

FILE: rtl/tag_markup_validator.sv
// ----------------------------------------------------------------------------
// tag_markup_validator: one-element tag/CDATA checker over a word stream
// result: verdict is in the output register in the cycle after the last word is accepted
// throughput: one word per cycle unless a pending result stalls the input, set by the parse state and stack cell row
// reset: rst_n clears parse state and the output register; stack needs none
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tag_markup_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res
);

    logic                  accept;
    logic                  verdict;
    logic                  out_valid_reg, out_valid_next;
    logic                  res_reg;
    tmv_pkg::entry_t       new_entry;
    tmv_pkg::stack_ctrl_t  ctrl;
    tmv_pkg::parser_stat_t stat;
    tmv_pkg::entry_t       cells [tmv_pkg::MaxDepth];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    tmv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .last      (last),
        .top_entry (cells[0]),
        .new_entry (new_entry),
        .ctrl      (ctrl),
        .stat      (stat),
        .verdict   (verdict)
    );

    // stack top sits in cell 0
    for (genvar i = 0; i < tmv_pkg::MaxDepth; i++)
    begin : g_cell
        tmv_pkg::entry_t up_entry;
        tmv_pkg::entry_t down_entry;

        if (i == 0)
        begin : g_top
            assign up_entry = new_entry;
        end
        else
        begin : g_mid
            assign up_entry = cells[i-1];
        end

        if (i == tmv_pkg::MaxDepth - 1)
        begin : g_bottom
            assign down_entry = cells[i];
        end
        else
        begin : g_inner
            assign down_entry = cells[i+1];
        end

        tmv_stack_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .up_entry   (up_entry),
            .down_entry (down_entry),
            .entry      (cells[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept && last)
            begin
                res_reg <= verdict;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_reg;

    `TMV_ASSERT(a_depth_bound, stat.count <= tmv_pkg::CountW'(tmv_pkg::MaxDepth))
    `TMV_ASSERT(a_push_pop_excl, !(ctrl.push && ctrl.pop))
    `TMV_ASSERT_MSG(a_root_empty, stat.root_closed |-> stat.count == '0, "root closed with stack not empty")
    `TMV_ASSERT_MSG(a_last_gives_word, (accept && last) |=> out_valid, "no result after last word")
    `TMV_ASSERT(a_fail_sticky, (stat.fail && !(accept && last)) |=> stat.fail)

endmodule
